// ----- hw/rtl/ipv6c_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv6c_pkg
// Shared types, constants and helpers for the IPv6 address text compressor.
// ----------------------------------------------------------------------------
package ipv6c_pkg;

	localparam int NUM_GROUPS  = 8;
	localparam int GROUP_BITS  = 16;
	localparam int IDX_W       = $clog2(NUM_GROUPS);
	localparam int RUN_W       = IDX_W + 1;
	localparam int CHAR_BITS   = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_BITS-1:0] CH_COLON   = 7'h3a;
	localparam logic [CHAR_BITS-1:0] CH_ZERO    = 7'h30;
	localparam logic [CHAR_BITS-1:0] CH_A_BIAS  = 7'h57; // 'a' - 10

	typedef logic [GROUP_BITS-1:0] group_t;
	typedef logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] grp_arr_t;

	// One classified address: groups plus the chosen zero run.
	typedef struct packed {
		grp_arr_t         grp;
		logic             has;
		logic [IDX_W-1:0] start;
		logic [RUN_W-1:0] len;
	} job_t;

	// Index of the highest nonzero nibble (0 for a zero group).
	function automatic logic [1:0] top_nib(input group_t g);
		logic [1:0] t;
		if (g[15:12] != 4'h0) begin
			t = 2'd3;
		end else if (g[11:8] != 4'h0) begin
			t = 2'd2;
		end else if (g[7:4] != 4'h0) begin
			t = 2'd1;
		end else begin
			t = 2'd0;
		end
		return t;
	endfunction

	// Lowercase hex digit.
	function automatic logic [CHAR_BITS-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_BITS-1:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {3'b000, nib};
		end else begin
			c = CH_A_BIAS + {3'b000, nib};
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/ipv6c_front.sv -----
// ----------------------------------------------------------------------------
// ipv6c_front
// Picks the zero run to be replaced by "::" for one incoming address.
// ----------------------------------------------------------------------------
module ipv6c_front (
	input  ipv6c_pkg::grp_arr_t grp,
	output ipv6c_pkg::job_t     job
);
	import ipv6c_pkg::*;

	logic [RUN_W-1:0] zrun;
	logic [RUN_W-1:0] len;
	logic [IDX_W-1:0] start;
	logic             has;

	// Eight narrow steps, one per group.
	always_comb begin
		zrun  = '0;
		len   = '0;
		start = '0;
		has   = 1'b0;
		for (int i = 0; i < NUM_GROUPS; i++) begin
			if (grp[i] == '0) begin
				zrun = zrun + RUN_W'(1);
			end else begin
				// interior run: ties go to the later one
				if (zrun >= len && zrun > RUN_W'(1)) begin
					start = IDX_W'(RUN_W'(i) - zrun);
					len   = zrun;
					has   = 1'b1;
				end
				zrun = '0;
			end
		end
		// trailing run: longer wins, a tie wins only against a leading run
		if (zrun > RUN_W'(1)) begin
			if (zrun > len) begin
				start = IDX_W'(RUN_W'(NUM_GROUPS) - zrun);
				len   = zrun;
				has   = 1'b1;
			end else if (zrun == len && has && start == '0) begin
				start = IDX_W'(RUN_W'(NUM_GROUPS) - zrun);
			end
		end
	end

	assign job.grp   = grp;
	assign job.has   = has;
	assign job.start = start;
	assign job.len   = len;

endmodule

// ----- hw/rtl/ipv6c_queue.sv -----
// ----------------------------------------------------------------------------
// ipv6c_queue
// Small FIFO of classified addresses between front and back.
// ----------------------------------------------------------------------------
module ipv6c_queue #(
	parameter int DEPTH = ipv6c_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  ipv6c_pkg::job_t wr_data,
	input  logic            rd_en,
	output ipv6c_pkg::job_t rd_data,
	output logic            full,
	output logic            empty
);
	import ipv6c_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] wr_next;
	logic [AW-1:0] rd_next;
	logic          do_wr;
	logic          do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];
	assign wr_next = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
	assign rd_next = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_next;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_next;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/ipv6c_back.sv -----
// ----------------------------------------------------------------------------
// ipv6c_back
// Character sequencer: walks one classified address and emits its text.
// ----------------------------------------------------------------------------
module ipv6c_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ipv6c_pkg::job_t                  job,
	input  logic                             job_vld,
	output logic                             job_take,
	input  logic                             pop,
	output logic                             empty,
	output logic [ipv6c_pkg::CHAR_BITS-1:0]  text_char,
	output logic                             last
);
	import ipv6c_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LEAD  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_DIGIT = 5'b01000,
		ST_SEP   = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	job_t                 cur_q;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [1:0]           nib_q, nib_d;
	logic                 out_vld_q;
	logic [CHAR_BITS-1:0] char_q;
	logic                 last_q;

	logic                 adv;
	logic                 emit;
	logic [CHAR_BITS-1:0] emit_char;
	logic                 emit_last;
	group_t               cur_grp;
	logic [RUN_W-1:0]     run_end;
	logic [IDX_W-1:0]     sep_next;

	assign adv      = !out_vld_q || pop;
	assign cur_grp  = cur_q.grp[idx_q];
	assign run_end  = {1'b0, idx_q} + cur_q.len;
	assign sep_next = idx_q + IDX_W'(1);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		nib_d     = nib_q;
		job_take  = 1'b0;
		emit      = 1'b0;
		emit_char = CH_COLON;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (job_vld) begin
					job_take = 1'b1;
					idx_d    = '0;
					if (job.has && job.start == '0) begin
						state_d = ST_LEAD;
					end else begin
						state_d = ST_DIGIT;
						nib_d   = top_nib(job.grp[0]);
					end
				end
			end
			ST_LEAD: begin
				if (adv) begin
					emit    = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (adv) begin
					emit = 1'b1;
					if (run_end[RUN_W-1]) begin
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						idx_d   = run_end[IDX_W-1:0];
						nib_d   = top_nib(cur_q.grp[run_end[IDX_W-1:0]]);
						state_d = ST_DIGIT;
					end
				end
			end
			ST_DIGIT: begin
				if (adv) begin
					emit      = 1'b1;
					emit_char = hex_char(cur_grp[{nib_q, 2'b00} +: 4]);
					if (nib_q != 2'd0) begin
						nib_d = nib_q - 2'd1;
					end else if (idx_q == IDX_W'(NUM_GROUPS - 1)) begin
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_SEP;
					end
				end
			end
			ST_SEP: begin
				if (adv) begin
					emit  = 1'b1;
					idx_d = sep_next;
					if (cur_q.has && sep_next == cur_q.start) begin
						state_d = ST_RUN;
					end else begin
						nib_d   = top_nib(cur_q.grp[sep_next]);
						state_d = ST_DIGIT;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			cur_q <= job;
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
		idx_q <= idx_d;
		nib_q <= nib_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_vld_q <= emit;
			end
		end
	end

	assign empty     = !out_vld_q;
	assign text_char = char_q;
	assign last      = last_q;

endmodule

// ----- hw/rtl/ipv6_address_text_compressor_core.sv -----
// ----------------------------------------------------------------------------
// ipv6_address_text_compressor_core
// Turns an IPv6 address (eight 16-bit groups) into its compressed text form,
// one ASCII character per output transfer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------------
//  address   in         push / full          group0 .. group7 (16 b each)
//  text      out        pop / empty          text_char (7 b), last (1 b)
//
// Flow: the front classifies an address in the cycle of its transfer and
// writes it to a QDEPTH-entry queue. The back sequencer takes one address
// into its job register, then emits one character per cycle while pop keeps
// up, 2 to 39 characters in all; it takes the next address only after the
// last character. The back's single character slot is what sets the rate.
// The first character passes the queue, the job register and the output
// register before it is visible. Reset clears queue pointers, the sequencer
// state and the output valid. A stall on pop freezes the back only; the
// front keeps taking addresses until the queue is full.
//
module ipv6_address_text_compressor_core #(
	parameter int QDEPTH = ipv6c_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  ipv6c_pkg::group_t               group0,
	input  ipv6c_pkg::group_t               group1,
	input  ipv6c_pkg::group_t               group2,
	input  ipv6c_pkg::group_t               group3,
	input  ipv6c_pkg::group_t               group4,
	input  ipv6c_pkg::group_t               group5,
	input  ipv6c_pkg::group_t               group6,
	input  ipv6c_pkg::group_t               group7,
	output logic                            empty,
	input  logic                            pop,
	output logic [ipv6c_pkg::CHAR_BITS-1:0] text_char,
	output logic                            last
);
	import ipv6c_pkg::*;

	grp_arr_t grp;
	job_t     front_job;
	job_t     head_job;
	logic     q_empty;
	logic     head_take;

	// group0 is the most significant group and goes out first
	assign grp[0] = group0;
	assign grp[1] = group1;
	assign grp[2] = group2;
	assign grp[3] = group3;
	assign grp[4] = group4;
	assign grp[5] = group5;
	assign grp[6] = group6;
	assign grp[7] = group7;

	// Front: zero-run selection, no state.
	ipv6c_front u_front (
		.grp (grp),
		.job (front_job)
	);

	// Decoupling queue; its full flag is the input back-pressure.
	ipv6c_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_job),
		.rd_en   (head_take),
		.rd_data (head_job),
		.full    (full),
		.empty   (q_empty)
	);

	// Back: character sequencer with a one-entry output register.
	ipv6c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_vld   (!q_empty),
		.job_take  (head_take),
		.pop       (pop),
		.empty     (empty),
		.text_char (text_char),
		.last      (last)
	);

	// A waiting character is always a hex digit or a colon.
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (text_char == CH_COLON
			|| (text_char >= 7'h30 && text_char <= 7'h39)
			|| (text_char >= 7'h61 && text_char <= 7'h66)))
		else $error("illegal text character");

	// An accepted address lands in the queue.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> !q_empty)
		else $error("accepted address missing from queue");

	// The back only takes an address the queue holds.
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		head_take |-> !q_empty)
		else $error("back took from an empty queue");

endmodule

// ----- bench/tb_ipv6_address_text_compressor_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv6_address_text_compressor_core
// Self-checking bench for the IPv6 address text compressor. Addresses go in
// as eight groups; every character that comes out is compared with the text
// that a local model of zero-run selection and hex printing predicts.
// ----------------------------------------------------------------------------
module tb_ipv6_address_text_compressor_core;
	import ipv6c_pkg::*;

	// Worst correct run: ~230 addresses x 39 chars, receiver idle 58% of the
	// time. The limit leaves a wide margin.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 50;

	localparam logic [CHAR_BITS-1:0] ASCII_ZERO    = 7'h30;
	localparam logic [CHAR_BITS-1:0] ASCII_LOWER_A = 7'h61;

	typedef group_t addr_t [NUM_GROUPS];

	typedef struct {
		logic [CHAR_BITS-1:0] ch;
		logic                 last;
	} text_beat_t;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push   = 1'b0;
	logic                 pop    = 1'b0;
	group_t               group0 = '0;
	group_t               group1 = '0;
	group_t               group2 = '0;
	group_t               group3 = '0;
	group_t               group4 = '0;
	group_t               group5 = '0;
	group_t               group6 = '0;
	group_t               group7 = '0;
	logic                 full;
	logic                 empty;
	logic [CHAR_BITS-1:0] text_char;
	logic                 last;

	// Characters still owed by the block, oldest first.
	text_beat_t text_q [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_errors      = 0;
	int n_sent        = 0;
	int n_directed    = 0;
	int n_chars       = 0;
	int n_addr_done   = 0;
	int n_cycles      = 0;

	ipv6_address_text_compressor_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.group0    (group0),
		.group1    (group1),
		.group2    (group2),
		.group3    (group3),
		.group4    (group4),
		.group5    (group5),
		.group6    (group6),
		.group7    (group7),
		.empty     (empty),
		.pop       (pop),
		.text_char (text_char),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs or drops characters.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Text predictor: pick the zero run, then print the groups.
	// ------------------------------------------------------------------------
	function automatic void predict_text(input addr_t a);
		logic [CHAR_BITS-1:0] chars [$];
		logic [3:0]           nib;
		bit                   has;
		int                   start;
		int                   len;
		int                   zrun;
		int                   i;
		int                   top;
		has   = 1'b0;
		start = 0;
		len   = 0;
		zrun  = 0;
		// Interior runs: a run closed by a nonzero group takes over on a tie,
		// so the later of two equal runs wins.
		for (i = 0; i < NUM_GROUPS; i++) begin
			if (a[i] == '0) begin
				zrun++;
			end else begin
				if (zrun >= len && zrun > 1) begin
					start = i - zrun;
					len   = zrun;
					has   = 1'b1;
				end
				zrun = 0;
			end
		end
		// Trailing run: wins if strictly longer, or on a tie with a run at
		// the very front.
		if (zrun > 1) begin
			if (zrun > len) begin
				start = NUM_GROUPS - zrun;
				len   = zrun;
				has   = 1'b1;
			end else if (zrun == len && has && start == 0) begin
				start = NUM_GROUPS - zrun;
			end
		end
		// Leading "::" needs one extra colon up front.
		if (has && start == 0) begin
			chars.push_back(CH_COLON);
		end
		i = 0;
		while (i < NUM_GROUPS) begin
			if (has && i == start) begin
				chars.push_back(CH_COLON);
				i += len;
			end
			if (i < NUM_GROUPS) begin
				// Skip leading zero nibbles, but always print at least one digit.
				top = 0;
				for (int k = 1; k < 4; k++) begin
					if (a[i][4*k +: 4] != 4'h0) begin
						top = k;
					end
				end
				for (int k = top; k >= 0; k--) begin
					nib = a[i][4*k +: 4];
					if (nib < 4'd10) begin
						chars.push_back(ASCII_ZERO + CHAR_BITS'(nib));
					end else begin
						chars.push_back(ASCII_LOWER_A + CHAR_BITS'(nib) - CHAR_BITS'(10));
					end
				end
				if (i < NUM_GROUPS - 1) begin
					chars.push_back(CH_COLON);
				end
				i++;
			end
		end
		foreach (chars[k]) begin
			text_q.push_back('{chars[k], (k == chars.size() - 1)});
		end
	endfunction

	// ------------------------------------------------------------------------
	// Sender: drives one address and holds it until the transfer happens.
	// push is left high so back-to-back addresses follow without a gap.
	// ------------------------------------------------------------------------
	task automatic send_address(input addr_t a);
		// idle cycles are rolled one cycle at a time
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		group0 <= a[0];
		group1 <= a[1];
		group2 <= a[2];
		group3 <= a[3];
		group4 <= a[4];
		group5 <= a[5];
		group6 <= a[6];
		group7 <= a[7];
		@(posedge clk);
		while (full) @(posedge clk);
		predict_text(a);
		n_sent++;
	endtask

	// Sender holds off until the whole backlog of text has come out.
	task automatic wait_drained();
		push <= 1'b0;
		while (text_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver and checker. Outputs are sampled at the edge, before the
	// block's own updates land; pop is re-rolled every cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_text
		text_beat_t want;
		if (arst_n && pop && !empty) begin
			if (text_q.size() == 0) begin
				$error("unexpected character transfer: text_char %h, last %b",
					text_char, last);
				n_errors++;
			end else begin
				want = text_q.pop_front();
				if (text_char !== want.ch) begin
					$error("text_char: expected %h, got %h", want.ch, text_char);
					n_errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					n_errors++;
				end
				n_chars++;
				if (want.last) begin
					n_addr_done++;
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------------

	// All zero, all ones, no run at all, lone zeros that must not compress.
	task automatic test_extremes();
		send_address('{16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_address('{16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 16'hffff, 16'hffff});
		send_address('{16'h0001, 16'h0001, 16'h0001, 16'h0001,
			16'h0001, 16'h0001, 16'h0001, 16'h0001});
		send_address('{16'h0000, 16'h0001, 16'h0000, 16'h0001,
			16'h0000, 16'h0001, 16'h0000, 16'h0001});
		send_address('{16'h0001, 16'h0000, 16'h0001, 16'h0000,
			16'h0001, 16'h0000, 16'h0001, 16'h0000});
	endtask

	// Tie-breaks and length contests between leading, interior and trailing runs.
	task automatic test_run_selection();
		// later of two equal interior runs
		send_address('{16'h0001, 16'h0000, 16'h0000, 16'h0001,
			16'h0000, 16'h0000, 16'h0001, 16'h0001});
		// longer earlier interior run stays
		send_address('{16'h0001, 16'h0000, 16'h0000, 16'h0000,
			16'h0001, 16'h0000, 16'h0000, 16'h0001});
		// trailing ties a run at the front: trailing wins
		send_address('{16'h0000, 16'h0000, 16'h0001, 16'h0001,
			16'h0001, 16'h0001, 16'h0000, 16'h0000});
		// trailing ties an interior run: interior stays
		send_address('{16'h0001, 16'h0000, 16'h0000, 16'h0001,
			16'h0001, 16'h0001, 16'h0000, 16'h0000});
		// trailing strictly longer
		send_address('{16'h0001, 16'h0000, 16'h0000, 16'h0001,
			16'h0001, 16'h0000, 16'h0000, 16'h0000});
		// interior longer than trailing
		send_address('{16'h0001, 16'h0000, 16'h0000, 16'h0000,
			16'h0001, 16'h0001, 16'h0000, 16'h0000});
	endtask

	// Runs touching either end, runs of maximum length, and short interior runs.
	task automatic test_run_edges();
		send_address('{16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0001});
		send_address('{16'h0001, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_address('{16'h0000, 16'h0000, 16'h0002, 16'h0003,
			16'h0004, 16'h0005, 16'h0006, 16'h0007});
		send_address('{16'h0000, 16'h0001, 16'h0000, 16'h0000,
			16'h0001, 16'h0001, 16'h0001, 16'h0001});
		send_address('{16'h0001, 16'h0001, 16'h0001, 16'h0000,
			16'h0000, 16'h0001, 16'h0001, 16'h0001});
	endtask

	// One to four digit groups and every hex letter.
	task automatic test_digit_widths();
		send_address('{16'h0001, 16'h0010, 16'h0100, 16'h1000,
			16'h8000, 16'h000f, 16'h00f0, 16'h0f00});
		send_address('{16'habcd, 16'hef01, 16'h2345, 16'h6789,
			16'h0a0b, 16'h00c0, 16'hd00e, 16'h0009});
		send_address('{16'h7fff, 16'h5555, 16'haaaa, 16'h0123,
			16'hfedc, 16'hba98, 16'h8001, 16'hffff});
	endtask

	// Random addresses. Most have a high share of zero groups so that runs
	// of every length and position come up; a few are fully random.
	function automatic addr_t random_address();
		addr_t a;
		int    zero_pct;
		zero_pct = ($urandom_range(9) < 2) ? 0 : $urandom_range(70, 20);
		foreach (a[i]) begin
			if ($urandom_range(99) < zero_pct) begin
				a[i] = '0;
			end else begin
				a[i] = group_t'($urandom_range(16'hffff, 1) >> (4 * $urandom_range(3)));
			end
		end
		return a;
	endfunction

	task automatic test_random(input int count, input int sender_pct,
		input int receiver_pct);
		addr_t a;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		repeat (count) begin
			a = random_address();
			send_address(a);
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		send_idle_pct = 7;
		recv_idle_pct = 58;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_run_selection();
		test_run_edges();
		test_digit_widths();
		// sender pauses until every directed character is out
		wait_drained();
		n_directed = n_sent;

		test_random(70, 7, 58);
		test_random(70, 58, 7);
		test_random(70, 0, 0);

		$display("Run covered %0d addresses (%0d directed, %0d random) and %0d characters,",
			n_sent, n_directed, n_sent - n_directed, n_chars);
		$display("with %0d complete address texts checked under three idle patterns.",
			n_addr_done);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- ipv6_address_text_compressor_core.f -----
hw/rtl/ipv6c_pkg.sv
hw/rtl/ipv6c_front.sv
hw/rtl/ipv6c_queue.sv
hw/rtl/ipv6c_back.sv
hw/rtl/ipv6_address_text_compressor_core.sv
bench/tb_ipv6_address_text_compressor_core.sv
